### sv/feb_pkg.sv
// Shared types and request codes for the FIFO-evicting blocklist.
`timescale 1ns / 1ps
package feb_pkg;

   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_REPORT = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] item_id;
   } feb_req_type;

   typedef struct packed {
      logic        was_listed;
      logic [15:0] fail_count;
      logic [6:0]  entry_count;
      logic        evicted;
      logic [31:0] evicted_id;
   } feb_rsp_type;

   // One table entry as it moves down the chain.
   typedef struct packed {
      logic        valid;
      logic [31:0] id;
      logic [15:0] count;
   } feb_entry_type;

   // Per-cycle commands broadcast to every cell.
   typedef struct packed {
      logic capture;   // register the compare result for the new request
      logic shift;     // take the neighbor's entry (insert at head)
      logic bump;      // saturating increment of the matching entry
      logic clear;     // drop every entry
   } feb_ctl_type;

endpackage

### sv/feb_cell.sv
// One blocklist slot: holds an entry, compares it, and shifts it to the next cell.
`timescale 1ns / 1ps
module feb_cell import feb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  feb_ctl_type   ctl,
   input  logic [31:0]   cmp_id,
   input  feb_entry_type prev_entry,
   output feb_entry_type entry,
   output logic          hit
);

   logic          valid_ff, valid_in;
   logic [31:0]   id_ff, id_in;
   logic [15:0]   count_ff, count_in;
   logic          hit_ff, hit_in;

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      count_in = count_ff;
      hit_in   = hit_ff;
      if (ctl.capture) begin
         hit_in = valid_ff && (id_ff == cmp_id);
      end
      priority if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.shift) begin
         valid_in = prev_entry.valid;
         id_in    = prev_entry.id;
         count_in = prev_entry.count;
      end else if (ctl.bump && hit_ff && count_ff != COUNT_MAX) begin
         count_in = count_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
      id_ff    <= id_in;
      count_ff <= count_in;
   end

   assign entry = '{valid: valid_ff, id: id_ff, count: count_ff};
   assign hit   = hit_ff;

endmodule

### sv/fifo_evicting_blocklist_unit.sv
// Top level of the FIFO-evicting blocklist: cell chain, control and result register.
`timescale 1ns / 1ps
// A bounded blocklist of 32-bit identifiers held in a row of CAPACITY cells in
// insertion order, newest at cell 0. A request is taken when start is high and
// busy is low; each request is then handled in order: first every cell compares
// its identifier against the request, and then the matches are gathered
// and the chain is updated (increment in place, shift-in of a new entry, or
// clear). The result then sits on rsp_data for exactly one cycle with
// rsp_valid high; the receiver cannot stall it, so it must take every result
// the cycle it appears. A new request may be taken in that same cycle, but
// none while one is still pending. An add to a full table pushes the oldest
// entry out of the last cell; its identifier is returned.
// Reset empties the table at once; there is no clearing pass.
module fifo_evicting_blocklist_unit import feb_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  feb_req_type req_data,
   output logic        rsp_valid,
   output feb_rsp_type rsp_data
);

   localparam int HW = $clog2(CAPACITY + 1);

   feb_ctl_type   ctl;
   feb_entry_type chain [CAPACITY+1];   // chain[i] feeds cell i, chain[i+1] is its output
   logic [CAPACITY-1:0] hits;

   logic          pending_ff, pending_in;
   feb_req_type   req_ff, req_in;
   logic [HW-1:0] held_ff, held_in;
   logic          rsp_valid_ff, rsp_valid_in;
   feb_rsp_type   rsp_ff, rsp_in;

   logic          accept;
   logic          hit_any;
   logic [15:0]   hit_count;
   feb_entry_type tail;
   logic [HW+6:0] held_wide;

   assign accept = start && !pending_ff;
   assign busy   = pending_ff;

   // new entry entering at the head of the chain
   assign chain[0] = '{valid: 1'b1, id: req_ff.item_id, count: 16'd1};
   assign tail     = chain[CAPACITY];

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      feb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .cmp_id     (req_data.item_id),
         .prev_entry (chain[g]),
         .entry      (chain[g+1]),
         .hit        (hits[g])
      );
   end

   // at most one cell matches, so an OR gathers its count
   always_comb begin
      hit_count = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_count = hit_count | (hits[i] ? chain[i+1].count : 16'd0);
      end
   end
   assign hit_any = |hits;

   always_comb begin
      pending_in   = pending_ff;
      req_in       = req_ff;
      held_in      = held_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctl          = '0;
      ctl.capture  = accept;

      if (accept) begin
         pending_in = 1'b1;
         req_in     = req_data;
      end

      if (pending_ff) begin
         pending_in   = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         unique case (req_ff.req_type)
            REQ_CLEAR: begin
               ctl.clear = 1'b1;
               held_in   = '0;
            end
            REQ_REPORT: begin
               if (hit_any) begin
                  ctl.bump          = 1'b1;
                  rsp_in.was_listed = 1'b1;
                  rsp_in.fail_count = (hit_count == COUNT_MAX) ? hit_count
                                                               : hit_count + 16'd1;
               end else begin
                  ctl.shift         = 1'b1;
                  rsp_in.fail_count = 16'd1;
                  // a valid last cell means the table is full: it falls off
                  rsp_in.evicted    = tail.valid;
                  rsp_in.evicted_id = tail.valid ? tail.id : 32'd0;
                  if (held_ff != HW'(CAPACITY)) begin
                     held_in = held_ff + HW'(1);
                  end
               end
            end
            default: begin
               // lookup, and the unused code acting as one
               rsp_in.was_listed = hit_any;
               rsp_in.fail_count = hit_any ? hit_count : 16'd0;
            end
         endcase
      end

      held_wide          = {7'd0, held_in};
      rsp_in.entry_count = pending_ff ? held_wide[6:0] : rsp_ff.entry_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### dv/fifo_evicting_blocklist_unit_tb.sv
// Self-checking testbench for the FIFO-evicting blocklist unit.
`timescale 1ns / 1ps
module fifo_evicting_blocklist_unit_tb;
   import feb_pkg::*;

   localparam int          CAPACITY       = 64;
   localparam logic [1:0]  REQ_UNUSED     = 2'd3;   // spare code, acts as a lookup
   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          TAIL_CYCLES    = 16;
   localparam int          RANDOM_ITEMS   = 1684;

   // One staged request: payload, idle cycles before it is offered, and whether
   // the sender must first wait for every outstanding result.
   typedef struct {
      feb_req_type req;
      int unsigned gap;
      bit          drain;
   } staged_req_type;

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   feb_req_type req_data = '0;
   logic        busy;
   logic        rsp_valid;
   feb_rsp_type rsp_data;

   staged_req_type pending_reqs[$];
   feb_rsp_type    expected_rsps[$];

   // Predicted blocklist contents: a ring of slots in insertion order.
   logic [31:0] held_ids[CAPACITY];
   logic [15:0] held_counts[CAPACITY];
   bit          held_valid[CAPACITY];
   int          ring_head  = 0;   // slot of the oldest entry
   int          held_total = 0;   // entries currently held

   int          mismatch_count = 0;
   int          stall_cycles   = 0;
   int unsigned idle_left      = 0;
   bit          gap_loaded     = 1'b0;
   int unsigned rsp_seen       = 0;
   feb_rsp_type want_rsp;

   fifo_evicting_blocklist_unit #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Expected result of one request; updates the predicted table as it goes.
   function automatic feb_rsp_type predict_blocklist(input feb_req_type r);
      feb_rsp_type o;
      int          hit;
      int          pos;
      o   = '0;
      hit = -1;
      if (r.req_type == REQ_CLEAR) begin
         for (int i = 0; i < CAPACITY; i++) held_valid[i] = 1'b0;
         ring_head  = 0;
         held_total = 0;
      end else begin
         for (int i = 0; i < CAPACITY; i++)
            if (hit < 0 && held_valid[i] && held_ids[i] == r.item_id) hit = i;
         if (hit >= 0) begin
            o.was_listed = 1'b1;
            // count sticks at its ceiling
            if (r.req_type == REQ_REPORT && held_counts[hit] != COUNT_MAX)
               held_counts[hit] = held_counts[hit] + 16'd1;
            o.fail_count = held_counts[hit];
         end else if (r.req_type == REQ_REPORT) begin
            if (held_total >= CAPACITY) begin
               // full: the oldest entry is pushed out and its slot reused
               pos          = ring_head;
               o.evicted    = 1'b1;
               o.evicted_id = held_ids[pos];
               ring_head    = (ring_head + 1) % CAPACITY;
            end else begin
               pos        = (ring_head + held_total) % CAPACITY;
               held_total = held_total + 1;
            end
            held_ids[pos]    = r.item_id;
            held_counts[pos] = 16'd1;
            held_valid[pos]  = 1'b1;
            o.fail_count     = 16'd1;
         end
      end
      o.entry_count = 7'(held_total);
      return o;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t ns, result %0d: %s", $time, rsp_seen, what);
   endtask

   function automatic void stage_req(input logic [1:0] kind, input logic [31:0] id,
                                     input int unsigned gap, input bit drain);
      staged_req_type s;
      s.req.req_type = kind;
      s.req.item_id  = id;
      s.gap          = gap;
      s.drain        = drain;
      pending_reqs   = {pending_reqs, s};
   endfunction

   // Driver: offers staged requests. A transfer happens at an edge with start
   // high and busy low; start is assigned at most once per edge.
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         gap_loaded  = 1'b0;
         idle_left   = 0;
      end else begin
         if (start && !busy)
            expected_rsps = {expected_rsps, predict_blocklist(req_data)};
         if (!start || !busy) begin
            if (!gap_loaded && pending_reqs.size() != 0) begin
               idle_left  = pending_reqs[0].gap;
               gap_loaded = 1'b1;
            end
            if (pending_reqs.size() != 0 && idle_left == 0 &&
                !(pending_reqs[0].drain && expected_rsps.size() != 0)) begin
               req_data   <= pending_reqs[0].req;
               start      <= 1'b1;
               pending_reqs.pop_front();
               gap_loaded  = 1'b0;
            end else begin
               start <= 1'b0;
               if (idle_left > 0) idle_left--;
            end
         end
      end
   end

   // Monitor: a result is valid for exactly one cycle, so it is taken every time.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         rsp_seen++;
         if (expected_rsps.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want_rsp = expected_rsps.pop_front();
            if (rsp_data.was_listed !== want_rsp.was_listed)
               report_mismatch($sformatf("was_listed got %0b want %0b",
                                         rsp_data.was_listed, want_rsp.was_listed));
            if (rsp_data.fail_count !== want_rsp.fail_count)
               report_mismatch($sformatf("fail_count got %0d want %0d",
                                         rsp_data.fail_count, want_rsp.fail_count));
            if (rsp_data.entry_count !== want_rsp.entry_count)
               report_mismatch($sformatf("entry_count got %0d want %0d",
                                         rsp_data.entry_count, want_rsp.entry_count));
            if (rsp_data.evicted !== want_rsp.evicted)
               report_mismatch($sformatf("evicted got %0b want %0b",
                                         rsp_data.evicted, want_rsp.evicted));
            if (rsp_data.evicted_id !== want_rsp.evicted_id)
               report_mismatch($sformatf("evicted_id got %h want %h",
                                         rsp_data.evicted_id, want_rsp.evicted_id));
         end
      end
   end

   // Watchdog: cycles with neither a request nor a result transfer.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("TIMEOUT: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [31:0] pool[$];
      logic [31:0] id;
      int unsigned pick;
      int unsigned round_len;
      int unsigned pool_size;
      int unsigned gap_mode;
      int unsigned gap;
      int unsigned random_done;

      for (int i = 0; i < CAPACITY; i++) begin
         held_ids[i]    = '0;
         held_counts[i] = '0;
         held_valid[i]  = 1'b0;
      end

      // Directed: empty table, field extremes, every code, clear.
      stage_req(REQ_LOOKUP, 32'h0000_0000, $urandom_range(0, 11), 1'b0);
      stage_req(REQ_REPORT, 32'h0000_0000, $urandom_range(0, 11), 1'b0);
      stage_req(REQ_REPORT, 32'h0000_0000, $urandom_range(0, 11), 1'b0);
      stage_req(REQ_LOOKUP, 32'h0000_0000, $urandom_range(0, 11), 1'b0);
      stage_req(REQ_REPORT, 32'hFFFF_FFFF, $urandom_range(0, 11), 1'b0);
      stage_req(REQ_LOOKUP, 32'hFFFF_FFFF, 0, 1'b0);
      stage_req(REQ_UNUSED, 32'h0000_0000, 0, 1'b0);          // spare code on a held id
      stage_req(REQ_UNUSED, 32'h1234_5678, 0, 1'b0);          // spare code on an absent id
      stage_req(REQ_REPORT, 32'h8000_0001, 0, 1'b0);
      stage_req(REQ_LOOKUP, 32'h8000_0000, $urandom_range(0, 11), 1'b0);  // one bit off
      stage_req(REQ_LOOKUP, 32'h1234_5678, 0, 1'b0);
      stage_req(REQ_CLEAR,  32'hFFFF_FFFF, $urandom_range(0, 11), 1'b0);
      stage_req(REQ_LOOKUP, 32'h0000_0000, 0, 1'b1);          // sender drains first
      stage_req(REQ_REPORT, 32'hFFFF_FFFF, 0, 1'b0);
      stage_req(REQ_CLEAR,  32'h0000_0000, 0, 1'b0);          // back-to-back clears
      stage_req(REQ_CLEAR,  32'h0000_0000, 0, 1'b0);

      // Random rounds: a pool of ids per round keeps hits, refills and
      // evictions frequent; a few stray ids and clears are mixed in.
      random_done = 0;
      while (random_done < RANDOM_ITEMS) begin
         pool.delete();
         pool_size = $urandom_range(8, 120);
         for (int k = 0; k < pool_size; k++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               id = 32'h0000_0000;
            else if (pick == 1)
               id = 32'hFFFF_FFFF;
            else if (pick < 4 && k > 0)
               id = pool[k - 1] ^ (32'h1 << $urandom_range(0, 31));  // near neighbor
            else
               id = $urandom();
            pool = {pool, id};
         end
         round_len = $urandom_range(40, 300);
         if (round_len > RANDOM_ITEMS - random_done)
            round_len = RANDOM_ITEMS - random_done;
         gap_mode  = $urandom_range(0, 2);
         for (int n = 0; n < round_len; n++) begin
            case (gap_mode)
               0: gap = 0;
               1: gap = $urandom_range(0, 11);
               default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 11) : 0;
            endcase
            id   = pool[$urandom_range(0, pool_size - 1)];
            pick = $urandom_range(0, 999);
            if (pick < 5)
               stage_req(REQ_CLEAR, $urandom(), gap, 1'b0);
            else if (pick < 35)
               stage_req(REQ_UNUSED, (pick < 20) ? id : $urandom(), gap, 1'b0);
            else if (pick < 80)
               stage_req(REQ_REPORT, $urandom(), gap, 1'b0);
            else if (pick < 120)
               stage_req(REQ_LOOKUP, $urandom(), gap, 1'b0);
            else if (pick < 650)
               stage_req(REQ_REPORT, id, gap, (n == 0) && ($urandom_range(0, 2) == 0));
            else
               stage_req(REQ_LOOKUP, id, gap, 1'b0);
         end
         random_done += round_len;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Wait until every staged request has transferred and every result came back.
      do @(posedge clock);
      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_rsps.size()));

      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

### fifo_evicting_blocklist_unit.f
sv/feb_pkg.sv
sv/feb_cell.sv
sv/fifo_evicting_blocklist_unit.sv
dv/fifo_evicting_blocklist_unit_tb.sv
